// ===== src/adpd_pkg.sv =====
// Package for the ambiguous DNA pair distance block.
// Holds widths, register indexes and the per-site distance functions.
// No dependencies.
package adpd_pkg;

	localparam int unsigned MAX_SITES = 65536;
	localparam int unsigned UNITS     = 840;

	localparam int unsigned BASE_W  = 8;
	localparam int unsigned UNITS_W = 10;
	localparam int unsigned SUM_W   = 26;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned DEN_W   = 26;
	localparam int unsigned QUOT_W  = 25;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned STEP_W  = 5;
	localparam int unsigned IN_W    = 16;
	localparam int unsigned OUT_W   = 48;
	localparam int unsigned NUC_MIN = 16;

	localparam logic REG_DISTANCE_MODEL    = 1'b0;
	localparam logic REG_PAIRWISE_DELETION = 1'b1;

	localparam logic MODEL_GENPOFAD    = 1'b0;
	localparam logic MODEL_MATCHSTATES = 1'b1;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [UNITS_W-1:0] units_t;

	function automatic logic [2:0] nuc_count(input logic [3:0] set);
		nuc_count = 3'(set[0]) + 3'(set[1]) + 3'(set[2]) + 3'(set[3]);
	endfunction

	// 840 divided by a small denominator; every such quotient is exact.
	function automatic units_t unit_share(input logic [3:0] den);
		case (den)
			4'd1:    unit_share = 10'd840;
			4'd2:    unit_share = 10'd420;
			4'd3:    unit_share = 10'd280;
			4'd4:    unit_share = 10'd210;
			4'd5:    unit_share = 10'd168;
			4'd6:    unit_share = 10'd140;
			4'd7:    unit_share = 10'd120;
			4'd8:    unit_share = 10'd105;
			default: unit_share = 10'd0;
		endcase
	endfunction

	function automatic units_t site_units(input base_t a, input base_t b, input logic model);
		logic [2:0]  na;
		logic [2:0]  nb;
		logic [2:0]  ns;
		logic [2:0]  nx;
		logic [2:0]  mx;
		logic [2:0]  num;
		logic [3:0]  den;
		logic [12:0] prod;
		na = nuc_count(a[7:4]);
		nb = nuc_count(b[7:4]);
		ns = nuc_count(a[7:4] & b[7:4]);
		nx = nuc_count(a[7:4] ^ b[7:4]);
		mx = (na >= nb) ? na : nb;
		if (model == MODEL_GENPOFAD) begin
			num = mx - ns;
			den = {1'b0, mx};
		end else begin
			num = nx;
			den = 4'(na) + 4'(nb);
		end
		prod = 13'(num) * 13'(unit_share(den));
		if (a == b) begin
			site_units = '0;
		end else if ((a[7:4] & b[7:4]) == 4'd0) begin
			site_units = UNITS_W'(UNITS);
		end else begin
			site_units = prod[UNITS_W-1:0];
		end
	endfunction

endpackage

// ===== src/ambiguous_dna_pair_distance.sv =====
// Top level of the ambiguous DNA pair distance block.
// Depends on adpd_pkg for widths, register indexes and site distance functions.
// A site that is not the last is taken while ready stays high, so the next site can follow.
// The last site of a pair is accepted, ST_MUL then forms the denominator, the restoring divider
// in ST_DIV yields one quotient bit a cycle, and ST_OUT loads the output register; ready stays
// low meanwhile and the next site is taken once the state machine is back in ST_IDLE.
// A pair with no counted site skips ST_MUL and ST_DIV and goes straight to ST_OUT.
// Throughput is one site per cycle within a pair; a result held by m_tready stalls input.
// Reset on arst_n clears the registers, the accumulators and the state machine.
module ambiguous_dna_pair_distance (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic                       cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [adpd_pkg::IN_W-1:0]  s_tdata,  // base_a [7:0], base_b [15:8]
	input  logic                       s_tlast,  // last_site
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [adpd_pkg::OUT_W-1:0] m_tdata   // distance_q24 [24:0], sites_counted [41:25],
	                                             // no_sites [42], zeros [47:43]
);
	import adpd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic                model_q;
	logic                pdel_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    div_sum_q;
	logic [CNT_W-1:0]    div_cnt_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic                nbit_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [STEP_W-1:0]   step_q;
	logic                empty_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	base_t               base_a;
	base_t               base_b;
	logic                in_fire;
	logic                counts;
	units_t              units;
	logic [SUM_W-1:0]    sum_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic [DEN_W:0]      shifted;
	logic                ge;
	logic [DEN_W-1:0]    rem_nx;
	logic [DEN_W:0]      den_prod;

	assign base_a   = s_tdata[7:0];
	assign base_b   = s_tdata[15:8];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		counts = 1'b1;
		if (pdel_q && ((base_a < BASE_W'(NUC_MIN)) || (base_b < BASE_W'(NUC_MIN)))) begin
			counts = 1'b0;
		end
		if (cnt_q >= CNT_W'(MAX_SITES)) begin
			counts = 1'b0;
		end
		units  = site_units(base_a, base_b, model_q);
		sum_nx = counts ? (sum_q + SUM_W'(units)) : sum_q;
		cnt_nx = counts ? (cnt_q + CNT_W'(1)) : cnt_q;
	end

	always_comb begin
		shifted  = {rem_q, nbit_q};
		ge       = (shifted >= {1'b0, den_q});
		rem_nx   = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		den_prod = (DEN_W+1)'(div_cnt_q) * (DEN_W+1)'(UNITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			model_q    <= 1'b0;
			pdel_q     <= 1'b0;
			sum_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			empty_q    <= 1'b0;
			step_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DISTANCE_MODEL:    model_q <= cfg_data;
					REG_PAIRWISE_DELETION: pdel_q  <= cfg_data;
					default:               model_q <= model_q;
				endcase
			end
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tlast) begin
							sum_q     <= '0;
							cnt_q     <= '0;
							div_sum_q <= sum_nx;
							div_cnt_q <= cnt_nx;
							empty_q   <= (cnt_nx == '0);
							quot_q    <= '0;
							state_q   <= (cnt_nx == '0) ? ST_OUT : ST_MUL;
						end else begin
							sum_q <= sum_nx;
							cnt_q <= cnt_nx;
						end
					end
				end
				ST_MUL: begin
					den_q   <= den_prod[DEN_W-1:0];
					rem_q   <= {1'b0, div_sum_q[SUM_W-1:1]};
					nbit_q  <= div_sum_q[0];
					step_q  <= STEP_W'(QUOT_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_nx;
					nbit_q <= 1'b0;
					quot_q <= {quot_q[QUOT_W-2:0], ge};
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_W'({empty_q,
						                      empty_q ? {CNT_W{1'b0}} : div_cnt_q,
						                      quot_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SITES))
		else $error("site count exceeds its limit");

	a_q24_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:0] <= 25'd16777216))
		else $error("distance above one");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[42]) |-> (m_tdata[41:0] == 42'd0))
		else $error("empty pair carries a non-zero result");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tlast) |=> !s_tready)
		else $error("input taken while the divider runs");
`endif

endmodule
